// File: rtl/lgsl_pkg.sv
`default_nettype none

package lgsl_pkg;

  localparam int unsigned CHANNEL_W = 4;
  localparam int unsigned LEVEL_W = 12;
  localparam int unsigned PERIOD_W = 24;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd4096;

  typedef enum logic [1:0] {
    PH_WAIT_HIGH = 2'd0,
    PH_RUN       = 2'd1,
    PH_SHIFT     = 2'd2,
    PH_LATCH     = 2'd3
  } phase_t;

  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_WRITE = 1'b1
  } req_t;

  typedef struct packed {
    logic                 req_type;
    logic [CHANNEL_W-1:0] channel;
    logic [LEVEL_W-1:0]   level;
  } in_item_t;

  typedef struct packed {
    logic serial_data;
    logic shift_clock;
    logic latch;
    logic blank;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/lgsl_stream_if.sv
`default_nettype none

interface lgsl_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/led_grayscale_serial_loader.sv
// Serial loader for a multi-channel grayscale LED driver.
// in_if carries one transaction per request: a tick (req_type 0) or a write of
// one channel level (req_type 1). Every input transaction gives exactly one
// out_if transaction with the pin levels serial_data, shift_clock, latch, blank.
// A write stores the level and marks an update pending. Ticks advance the
// blank-period counter; on expiry blank rises and, with an update pending,
// CHANNELS*LEVEL_BITS bits go out one per tick, highest channel and MSB first,
// followed by one latch tick, after which blank drops.
// cfg_wr_en/cfg_wr_data set the blank period in ticks (0 acts as 1); write it
// only while no transaction is in flight.
// A result is registered; it waits in the skid register while out_r is full.
// Throughput: one transaction per cycle while in_ready is high.
// A two-entry output stage (result register plus skid register) keeps in_ready
// high while one result waits; with the receiver stalled, one more transaction
// is taken and in_ready then drops until out_ready returns.
// Reset clears the levels, the pending mark and the counter, sets the period
// to 4096 and starts in the counting phase with blank high.
`default_nettype none

module led_grayscale_serial_loader #(
  parameter int unsigned CHANNELS   = 16,
  parameter int unsigned LEVEL_BITS = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  lgsl_stream_if.sink                          in_if,
  lgsl_stream_if.source                        out_if,
  input  wire logic                            cfg_wr_en,
  input  wire logic [lgsl_pkg::PERIOD_W-1:0]   cfg_wr_data
);

  localparam int unsigned CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CH_XW = (CH_IW > lgsl_pkg::CHANNEL_W) ? CH_IW : lgsl_pkg::CHANNEL_W;
  localparam int unsigned BT_IW = (LEVEL_BITS > 1) ? $clog2(LEVEL_BITS) : 1;
  localparam int unsigned LV_XW = (LEVEL_BITS > lgsl_pkg::LEVEL_W) ? LEVEL_BITS
                                                                    : lgsl_pkg::LEVEL_W;
  localparam logic [CH_IW-1:0] CH_LAST = CH_IW'(CHANNELS - 1);
  localparam logic [BT_IW-1:0] BT_LAST = BT_IW'(LEVEL_BITS - 1);

  logic [lgsl_pkg::PERIOD_W-1:0] period_r;
  logic [LEVEL_BITS-1:0]         levels_r [CHANNELS];
  logic                          pending_r, pending_nxt;
  logic [lgsl_pkg::PERIOD_W-1:0] cnt_r, cnt_nxt;
  logic [CH_IW-1:0]              ch_idx_r, ch_idx_nxt;
  logic [BT_IW-1:0]              bit_idx_r, bit_idx_nxt;
  lgsl_pkg::phase_t              phase_r, phase_nxt;

  lgsl_pkg::out_item_t out_r, skid_r, res;
  logic                out_valid_r, skid_valid_r;

  logic                          accept, out_fire, is_write, ch_ok, expired;
  logic [CH_XW-1:0]              ch_ext;
  logic [CH_IW-1:0]              wr_idx;
  logic [LV_XW-1:0]              lvl_ext;
  logic [lgsl_pkg::PERIOD_W-1:0] period_eff, cnt_inc;

  assign accept   = in_if.valid && in_if.ready;
  assign out_fire = out_valid_r && out_if.ready;
  assign is_write = (in_if.data.req_type == lgsl_pkg::REQ_WRITE);
  assign ch_ext   = CH_XW'(in_if.data.channel);
  assign wr_idx   = ch_ext[CH_IW-1:0];
  assign ch_ok    = (32'(in_if.data.channel) < 32'(CHANNELS));
  assign lvl_ext  = LV_XW'(in_if.data.level);

  assign period_eff = (period_r == '0) ? lgsl_pkg::PERIOD_W'(1) : period_r;
  assign cnt_inc    = cnt_r + lgsl_pkg::PERIOD_W'(1);
  assign expired    = (cnt_inc >= period_eff);

  assign in_if.ready  = !skid_valid_r;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    pending_nxt = pending_r;
    cnt_nxt     = cnt_r;
    ch_idx_nxt  = ch_idx_r;
    bit_idx_nxt = bit_idx_r;
    if (is_write) begin
      if (ch_ok) begin
        pending_nxt = 1'b1;
      end
    end else begin
      case (phase_r)
        lgsl_pkg::PH_SHIFT: begin
          if (bit_idx_r == '0) begin
            bit_idx_nxt = BT_LAST;
            if (ch_idx_r == '0) begin
              ch_idx_nxt = CH_LAST;
              phase_nxt  = lgsl_pkg::PH_LATCH;
            end else begin
              ch_idx_nxt = ch_idx_r - CH_IW'(1);
            end
          end else begin
            bit_idx_nxt = bit_idx_r - BT_IW'(1);
          end
        end
        lgsl_pkg::PH_LATCH: begin
          pending_nxt = 1'b0;
          cnt_nxt     = '0;
          phase_nxt   = lgsl_pkg::PH_RUN;
        end
        lgsl_pkg::PH_WAIT_HIGH, lgsl_pkg::PH_RUN: begin
          if (expired) begin
            cnt_nxt = '0;
            if (pending_r) begin
              ch_idx_nxt  = CH_LAST;
              bit_idx_nxt = BT_LAST;
              phase_nxt   = lgsl_pkg::PH_SHIFT;
            end else begin
              phase_nxt = lgsl_pkg::PH_RUN;
            end
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        default: begin
          phase_nxt = lgsl_pkg::PH_WAIT_HIGH;
        end
      endcase
    end
  end

  // pin levels for this transaction
  always_comb begin
    res             = '0;
    res.blank       = (phase_r != lgsl_pkg::PH_RUN);
    if (!is_write) begin
      case (phase_r)
        lgsl_pkg::PH_SHIFT: begin
          res.serial_data = levels_r[ch_idx_r][bit_idx_r];
          res.shift_clock = 1'b1;
          res.blank       = 1'b1;
        end
        lgsl_pkg::PH_LATCH: begin
          res.latch = 1'b1;
          res.blank = 1'b1;
        end
        lgsl_pkg::PH_WAIT_HIGH, lgsl_pkg::PH_RUN: begin
          if (expired) begin
            res.blank = 1'b1;
          end
        end
        default: begin
          res.blank = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= lgsl_pkg::PERIOD_RESET;
    end else if (cfg_wr_en) begin
      period_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        levels_r[i] <= '0;
      end
    end else if (accept && is_write && ch_ok) begin
      levels_r[wr_idx] <= lvl_ext[LEVEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= lgsl_pkg::PH_WAIT_HIGH;
      pending_r <= 1'b0;
      cnt_r     <= '0;
      ch_idx_r  <= CH_LAST;
      bit_idx_r <= BT_LAST;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      pending_r <= pending_nxt;
      cnt_r     <= cnt_nxt;
      ch_idx_r  <= ch_idx_nxt;
      bit_idx_r <= bit_idx_nxt;
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (accept) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!out_valid_r || out_fire) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end else if (out_fire && skid_valid_r) begin
      out_r <= skid_r;
    end
  end

endmodule

`default_nettype wire

// File: verif/led_grayscale_serial_loader_test.sv
`timescale 1ns / 1ps

module led_grayscale_serial_loader_test;

  localparam int N_CH = 16;
  localparam int LVL_BITS = lgsl_pkg::LEVEL_W;
  localparam int FRAME_BITS = N_CH * LVL_BITS;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [lgsl_pkg::PERIOD_W-1:0] cfg_wr_data = '0;

  lgsl_stream_if #(.payload_t(lgsl_pkg::in_item_t)) in_if ();
  lgsl_stream_if #(.payload_t(lgsl_pkg::out_item_t)) out_if ();

  led_grayscale_serial_loader u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_if),
    .out_if(out_if),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #2 clk = ~clk;

  // pin model state
  logic [LVL_BITS-1:0]           lvl_store [N_CH];
  logic                          pend;
  logic [lgsl_pkg::PERIOD_W-1:0] cnt;
  logic [7:0]                    pos;
  lgsl_pkg::phase_t              ph;
  logic [lgsl_pkg::PERIOD_W-1:0] period_reg;

  lgsl_pkg::in_item_t  req_q [$];
  lgsl_pkg::out_item_t pins_q [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          in_taken = 1'b0;
  int unsigned stall_cycles = 0;
  int unsigned n_err = 0;
  int unsigned n_in = 0;
  int unsigned n_out = 0;
  int unsigned n_writes = 0;
  int unsigned n_latch = 0;
  int unsigned n_cfg = 0;

  function automatic lgsl_pkg::out_item_t next_pins(lgsl_pkg::in_item_t it);
    lgsl_pkg::out_item_t           r;
    logic [lgsl_pkg::PERIOD_W-1:0] per;
    logic [lgsl_pkg::PERIOD_W-1:0] nxt;
    int                            p;
    r = '0;
    if (it.req_type == lgsl_pkg::REQ_WRITE) begin
      lvl_store[it.channel] = it.level;
      pend = 1'b1;
      r.blank = (ph != lgsl_pkg::PH_RUN);
    end else begin
      case (ph)
        lgsl_pkg::PH_SHIFT: begin
          p = pos;
          r.serial_data = lvl_store[N_CH - 1 - p / LVL_BITS][LVL_BITS - 1 - p % LVL_BITS];
          r.shift_clock = 1'b1;
          r.blank = 1'b1;
          if (p == FRAME_BITS - 1) begin
            pos = '0;
            ph = lgsl_pkg::PH_LATCH;
          end else begin
            pos = pos + 8'd1;
          end
        end
        lgsl_pkg::PH_LATCH: begin
          pend = 1'b0;
          cnt = '0;
          pos = '0;
          ph = lgsl_pkg::PH_RUN;
          r.latch = 1'b1;
          r.blank = 1'b1;
        end
        default: begin
          per = (period_reg == '0) ? lgsl_pkg::PERIOD_W'(1) : period_reg;
          nxt = cnt + lgsl_pkg::PERIOD_W'(1);
          if (nxt >= per) begin
            cnt = '0;
            r.blank = 1'b1;
            if (pend) begin
              pos = '0;
              ph = lgsl_pkg::PH_SHIFT;
            end else begin
              ph = lgsl_pkg::PH_RUN;
            end
          end else begin
            cnt = nxt;
            r.blank = (ph != lgsl_pkg::PH_RUN);
          end
        end
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", n_out, msg);
    n_err++;
  endtask

  task automatic check_pins(input lgsl_pkg::out_item_t got);
    lgsl_pkg::out_item_t exp;
    if (pins_q.size() == 0) begin
      report_mismatch("result with no transaction outstanding");
    end else begin
      exp = pins_q.pop_front();
      if (got.serial_data !== exp.serial_data)
        report_mismatch($sformatf("serial_data exp %0b got %0b",
                                  exp.serial_data, got.serial_data));
      if (got.shift_clock !== exp.shift_clock)
        report_mismatch($sformatf("shift_clock exp %0b got %0b",
                                  exp.shift_clock, got.shift_clock));
      if (got.latch !== exp.latch)
        report_mismatch($sformatf("latch exp %0b got %0b", exp.latch, got.latch));
      if (got.blank !== exp.blank)
        report_mismatch($sformatf("blank exp %0b got %0b", exp.blank, got.blank));
    end
  endtask

  // monitor and scoreboard
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n) begin
      if (cfg_wr_en) begin
        period_reg = cfg_wr_data;
      end
      if (out_if.valid && out_if.ready) begin
        check_pins(out_if.data);
        if (out_if.data.latch === 1'b1) begin
          n_latch++;
        end
        n_out++;
      end
      if (in_if.valid && in_if.ready) begin
        pins_q.push_back(next_pins(in_if.data));
        in_taken = 1'b1;
        n_in++;
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("no transaction for %0d cycles", STALL_LIMIT);
          $display("led_grayscale_serial_loader_test NOT OK");
          $finish;
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_if.valid || in_taken) begin
        if (req_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.data <= req_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  task automatic push_req(input lgsl_pkg::req_t kind,
                          input logic [lgsl_pkg::CHANNEL_W-1:0] ch,
                          input logic [lgsl_pkg::LEVEL_W-1:0] lvl);
    lgsl_pkg::in_item_t it;
    it.req_type = kind;
    it.channel = ch;
    it.level = lvl;
    if (kind == lgsl_pkg::REQ_WRITE) begin
      n_writes++;
    end
    req_q.push_back(it);
  endtask

  task automatic drain();
    while (req_q.size() != 0 || in_if.valid || pins_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic set_period(input logic [lgsl_pkg::PERIOD_W-1:0] p);
    drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= p;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    n_cfg++;
  endtask

  function automatic logic [lgsl_pkg::LEVEL_W-1:0] pick_level();
    case ($urandom_range(3, 0))
      0: return '0;
      1: return '1;
      default: return lgsl_pkg::LEVEL_W'($urandom_range(4095, 0));
    endcase
  endfunction

  task automatic run_segment(input logic [lgsl_pkg::PERIOD_W-1:0] p, input int n,
                             input int wr_pct);
    set_period(p);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99, 0) < wr_pct) begin
        push_req(lgsl_pkg::REQ_WRITE, lgsl_pkg::CHANNEL_W'($urandom_range(15, 0)),
                 pick_level());
      end else begin
        push_req(lgsl_pkg::REQ_TICK, '0, '0);
      end
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    send_idle_pct = 31;
    recv_idle_pct = 81;
    foreach (lvl_store[i]) lvl_store[i] = '0;
    pend = 1'b0;
    cnt = '0;
    pos = '0;
    ph = lgsl_pkg::PH_WAIT_HIGH;
    period_reg = lgsl_pkg::PERIOD_RESET;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default period, blank high after reset
    push_req(lgsl_pkg::REQ_TICK, '0, '0);
    push_req(lgsl_pkg::REQ_WRITE, 4'd0, 12'h000);
    push_req(lgsl_pkg::REQ_WRITE, 4'd15, 12'hFFF);
    push_req(lgsl_pkg::REQ_WRITE, 4'd5, 12'hAAA);
    push_req(lgsl_pkg::REQ_WRITE, 4'd10, 12'h555);
    push_req(lgsl_pkg::REQ_WRITE, 4'd1, 12'h001);
    push_req(lgsl_pkg::REQ_WRITE, 4'd14, 12'h800);
    push_req(lgsl_pkg::REQ_TICK, '0, '0);
    push_req(lgsl_pkg::REQ_TICK, '0, '0);

    // zero period expires on the first tick, then a rewrite mid-shift
    set_period('0);
    repeat (4) push_req(lgsl_pkg::REQ_TICK, '0, '0);
    push_req(lgsl_pkg::REQ_WRITE, 4'd15, 12'h000);
    repeat (3) push_req(lgsl_pkg::REQ_TICK, '0, '0);
    push_req(lgsl_pkg::REQ_WRITE, 4'd0, 12'hFFF);
    push_req(lgsl_pkg::REQ_TICK, '0, '0);
    push_req(lgsl_pkg::REQ_WRITE, 4'd7, 12'h0F0);
    push_req(lgsl_pkg::REQ_TICK, '0, '0);

    run_segment(24'd1, 250, 8);
    run_segment(24'd5, 150, 25);
    run_segment(24'hFFFFFF, 60, 30);

    send_idle_pct = 81;
    recv_idle_pct = 31;
    run_segment(24'd0, 250, 5);
    run_segment(24'd23, 150, 15);
    run_segment(lgsl_pkg::PERIOD_W'($urandom_range(64, 2)), 150, 10);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_segment(24'd2, 250, 10);
    run_segment(24'd3, 200, 3);
    run_segment(lgsl_pkg::PERIOD_RESET, 80, 40);

    drain();
    repeat (8) @(posedge clk);
    if (pins_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pins_q.size()));
    end
    $display("covered %0d transactions (%0d channel writes) over %0d blank period settings",
             n_in, n_writes, n_cfg);
    $display("checked %0d pin results including %0d latch pulses, %0d mismatches",
             n_out, n_latch, n_err);
    if (n_err == 0) begin
      $display("led_grayscale_serial_loader_test OK");
    end else begin
      $display("led_grayscale_serial_loader_test NOT OK");
    end
    $finish;
  end

endmodule
